// ===== hdl/pfpa_pkg.sv =====
package pfpa_pkg;

	localparam logic [7:0] HEADER_BYTE = 8'hAA;
	localparam logic [7:0] COMMAND_BYTE = 8'hC0;
	localparam int DATA_BYTES = 6;
	localparam logic [15:0] READING_LIMIT_RST = 16'd9999;
	localparam logic [15:0] AVERAGE_LIMIT_RST = 16'd999;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_STROBE = 1'b1;

	localparam logic KIND_READING = 1'b0;
	localparam logic KIND_AVERAGE = 1'b1;

	localparam logic REG_READING_LIMIT = 1'b0;
	localparam logic REG_AVERAGE_LIMIT = 1'b1;

	typedef struct packed {
		logic       command;
		logic [7:0] rx_byte;
	} sample_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] fine_value;
		logic [15:0] coarse_value;
	} result_t;

	typedef struct packed {
		logic [15:0] fine;
		logic [15:0] coarse;
	} pair_t;

	typedef struct packed {
		logic  done;
		pair_t fresh;
		pair_t latest;
	} frame_t;

endpackage

// ===== hdl/pfpa_cell.sv =====
module pfpa_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  pfpa_pkg::pair_t d,
	output pfpa_pkg::pair_t q
);
	import pfpa_pkg::*;

	pair_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else if (en) begin
			data_q <= d;
		end
	end

	assign q = data_q;

endmodule

// ===== hdl/pfpa_frame.sv =====
module pfpa_frame (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic [7:0]     rx_byte,
	input  logic [15:0]    reading_limit,
	output pfpa_pkg::frame_t fo
);
	import pfpa_pkg::*;

	typedef enum logic [4:0] {
		ST_HUNT = 5'b00001,
		ST_CMD  = 5'b00010,
		ST_DATA = 5'b00100,
		ST_CSUM = 5'b01000,
		ST_TAIL = 5'b10000
	} state_t;

	localparam int CNT_W = $clog2(DATA_BYTES);

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [7:0]       csum_q;
	logic             pass_q;
	logic [7:0]       bytes_q [DATA_BYTES];
	pair_t            latest_q;
	logic [15:0]      fine_raw;
	logic [15:0]      coarse_raw;
	pair_t            fresh;
	logic             done;

	// bytes shift in at entry 0, so the first data byte ends up in the last entry
	assign fine_raw = {bytes_q[DATA_BYTES-2], bytes_q[DATA_BYTES-1]};
	assign coarse_raw = {bytes_q[DATA_BYTES-4], bytes_q[DATA_BYTES-3]};

	always_comb begin
		fresh.fine = (fine_raw > reading_limit) ? reading_limit : fine_raw;
		fresh.coarse = (coarse_raw > reading_limit) ? reading_limit : coarse_raw;
	end

	assign done = en && (state_q == ST_TAIL) && pass_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
			count_q <= '0;
			csum_q <= '0;
			pass_q <= 1'b0;
			latest_q <= '0;
		end else if (en) begin
			unique case (state_q)
				ST_CMD: begin
					if (rx_byte == COMMAND_BYTE) begin
						csum_q <= '0;
						count_q <= '0;
						state_q <= ST_DATA;
					end else begin
						state_q <= ST_HUNT;
					end
				end
				ST_DATA: begin
					csum_q <= csum_q + rx_byte;
					count_q <= count_q + 1'b1;
					if (count_q == CNT_W'(DATA_BYTES - 1)) begin
						state_q <= ST_CSUM;
					end
				end
				ST_CSUM: begin
					pass_q <= (csum_q == rx_byte);
					state_q <= ST_TAIL;
				end
				ST_TAIL: begin
					state_q <= ST_HUNT;
					if (pass_q) begin
						latest_q <= fresh;
					end
				end
				default: begin
					state_q <= (rx_byte == HEADER_BYTE) ? ST_CMD : ST_HUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en && state_q == ST_DATA) begin
			bytes_q[0] <= rx_byte;
			for (int i = 1; i < DATA_BYTES; i++) begin
				bytes_q[i] <= bytes_q[i-1];
			end
		end
	end

	always_comb begin
		fo.done = done;
		fo.fresh = fresh;
		fo.latest = latest_q;
	end

endmodule

// ===== hdl/pfpa_avg_div.sv =====
module pfpa_avg_div #(
	parameter int WINDOW = 30,
	parameter int SUM_W = 21
) (
	input  logic             clk,
	input  logic             en,
	input  logic [SUM_W-1:0] sum,
	output logic [15:0]      quot
);
	localparam int HALF = 5 * WINDOW;
	localparam int DIV = 10 * WINDOW;
	localparam int X_W = SUM_W + 1;
	localparam int DIV_W = $clog2(DIV);
	localparam int M_W = X_W - DIV_W + 1;
	localparam int Q_W = X_W - DIV_W + 1;
	localparam int P_W = X_W + M_W;
	localparam longint RECIP = (longint'(1) << X_W) / DIV;

	logic [X_W-1:0] x_s1;
	logic [X_W-1:0] x_s2;
	logic [P_W-1:0] prod_s2;
	logic [Q_W-1:0] quot_s3;
	logic [Q_W-1:0] q_est;
	logic [X_W-1:0] rem;

	// estimate is floor or one below: fix with a single remainder compare
	assign q_est = Q_W'(prod_s2 >> X_W);
	assign rem = x_s2 - X_W'(X_W'(q_est) * X_W'(DIV));

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= {1'b0, sum} + X_W'(HALF);
			prod_s2 <= P_W'(x_s1) * P_W'(RECIP);
			x_s2 <= x_s1;
			quot_s3 <= (rem >= X_W'(DIV)) ? q_est + 1'b1 : q_est;
		end
	end

	assign quot = 16'(quot_s3);

endmodule

// ===== hdl/particle_frame_parser_averager.sv =====
// Channel   Direction  Handshake                     Payload
// sample    in         sample_valid / sample_ready   sample_t (command, rx_byte)
// result    out        result_valid / result_ready   result_t (kind, fine/coarse value)
// cfg       in         cfg_we                        cfg_index, cfg_data
//
// One transaction per cycle unless a held result stalls; a result passes stages s1, s2,
// s3 (the three-stage constant divider behind the window sums) and the output register.
// Reset clears the parser, the latest readings, every window cell and the sums, and loads
// the default limits. A held result with result_ready low freezes the whole pipeline and
// drops sample_ready.
module particle_frame_parser_averager #(
	parameter int WINDOW = 30
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_ready,
	input  pfpa_pkg::sample_t sample,
	output logic              result_valid,
	input  logic              result_ready,
	output pfpa_pkg::result_t result,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [15:0]       cfg_data
);
	import pfpa_pkg::*;

	localparam int SUM_W = 16 + $clog2(WINDOW);

	logic        adv;
	logic        accept;
	logic        strobe;
	logic [15:0] reading_limit_q;
	logic [15:0] average_limit_q;
	frame_t      fo;
	pair_t       chain [WINDOW+1];
	logic [SUM_W-1:0] fine_sum_q;
	logic [SUM_W-1:0] coarse_sum_q;
	logic [SUM_W-1:0] fine_sum_next;
	logic [SUM_W-1:0] coarse_sum_next;
	logic [15:0] fine_avg;
	logic [15:0] coarse_avg;
	logic        v_s1, v_s2, v_s3;
	logic        kind_s1, kind_s2, kind_s3;
	pair_t       rd_s1, rd_s2, rd_s3;
	logic        out_valid_q;
	result_t     out_q;

	assign adv = !out_valid_q || result_ready;
	assign sample_ready = adv;
	assign accept = sample_valid && adv;
	assign strobe = accept && (sample.command == CMD_STROBE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reading_limit_q <= READING_LIMIT_RST;
			average_limit_q <= AVERAGE_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_READING_LIMIT: reading_limit_q <= cfg_data;
				REG_AVERAGE_LIMIT: average_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	pfpa_frame u_frame (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (accept && (sample.command == CMD_BYTE)),
		.rx_byte       (sample.rx_byte),
		.reading_limit (reading_limit_q),
		.fo            (fo)
	);

	// the window is a shift chain: what falls off the far end is the entry it replaces
	assign chain[0] = fo.latest;

	for (genvar g = 0; g < WINDOW; g++) begin : g_cell
		pfpa_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (strobe),
			.d      (chain[g]),
			.q      (chain[g+1])
		);
	end

	assign fine_sum_next = fine_sum_q - SUM_W'(chain[WINDOW].fine) + SUM_W'(fo.latest.fine);
	assign coarse_sum_next = coarse_sum_q - SUM_W'(chain[WINDOW].coarse)
		+ SUM_W'(fo.latest.coarse);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fine_sum_q <= '0;
			coarse_sum_q <= '0;
		end else if (strobe) begin
			fine_sum_q <= fine_sum_next;
			coarse_sum_q <= coarse_sum_next;
		end
	end

	pfpa_avg_div #(.WINDOW(WINDOW), .SUM_W(SUM_W)) u_div_fine (
		.clk  (clk),
		.en   (adv),
		.sum  (fine_sum_next),
		.quot (fine_avg)
	);

	pfpa_avg_div #(.WINDOW(WINDOW), .SUM_W(SUM_W)) u_div_coarse (
		.clk  (clk),
		.en   (adv),
		.sum  (coarse_sum_next),
		.quot (coarse_avg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= strobe || fo.done;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= strobe ? KIND_AVERAGE : KIND_READING;
			rd_s1 <= fo.fresh;
			kind_s2 <= kind_s1;
			rd_s2 <= rd_s1;
			kind_s3 <= kind_s2;
			rd_s3 <= rd_s2;
			out_q.kind <= kind_s3;
			if (kind_s3 == KIND_AVERAGE) begin
				out_q.fine_value <= (fine_avg > average_limit_q) ? average_limit_q : fine_avg;
				out_q.coarse_value <= (coarse_avg > average_limit_q) ? average_limit_q
					: coarse_avg;
			end else begin
				out_q.fine_value <= rd_s3.fine;
				out_q.coarse_value <= rd_s3.coarse;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result = out_q;

endmodule
